// File: src/mfcd_pkg.sv
// ----------------------------------------------------------------------------
// mfcd_pkg
// Shared widths, reset values, register indexes and stage payload types for
// the motion fall and collision detector.
// ----------------------------------------------------------------------------
package mfcd_pkg;

  localparam int AxisW     = 16;
  localparam int AngleW    = 12;
  localparam int AngleLimW = 11;
  localparam int LimitW    = 16;
  localparam int SquareW   = 31;
  localparam int SumW      = 32;
  localparam int MagW      = 16;
  localparam int CfgIndexW = 2;
  localparam int CfgDataW  = 16;

  localparam logic [AngleLimW-1:0] AngleLimitReset = AngleLimW'(600);
  localparam logic [LimitW-1:0]    AccelLowReset   = LimitW'(10000);
  localparam logic [LimitW-1:0]    AccelHighReset  = LimitW'(20000);
  localparam logic [LimitW-1:0]    RateLimitReset  = LimitW'(100);

  typedef enum logic [CfgIndexW-1:0] {
    REG_ANGLE_LIMIT,
    REG_ACCEL_LOW,
    REG_ACCEL_HIGH,
    REG_RATE_LIMIT
  } cfg_reg_t;

  typedef struct packed {
    logic            valid;
    logic            tilt;
    logic [SumW-1:0] accel_sum;
    logic [SumW-1:0] rate_sum;
  } mfcd_sum_t;

  typedef struct packed {
    logic            valid;
    logic            tilt;
    logic [MagW-1:0] accel_mag;
    logic [MagW-1:0] rate_mag;
  } mfcd_root_t;

endpackage

// File: src/mfcd_ifs.sv
// ----------------------------------------------------------------------------
// mfcd_ifs
// Valid/ready channels for samples and results.
// ----------------------------------------------------------------------------
interface mfcd_sample_if;
  import mfcd_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [AxisW-1:0]  accel_x;
  logic signed [AxisW-1:0]  accel_y;
  logic signed [AxisW-1:0]  accel_z;
  logic signed [AxisW-1:0]  rate_x;
  logic signed [AxisW-1:0]  rate_y;
  logic signed [AxisW-1:0]  rate_z;
  logic signed [AngleW-1:0] pitch_tenths;
  logic signed [AngleW-1:0] roll_tenths;

  modport source (
    output valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
           pitch_tenths, roll_tenths,
    input  ready
  );

  modport sink (
    input  valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
           pitch_tenths, roll_tenths,
    output ready
  );
endinterface

interface mfcd_result_if;
  import mfcd_pkg::*;

  logic            valid;
  logic            ready;
  logic [MagW-1:0] accel_magnitude;
  logic [MagW-1:0] rate_magnitude;
  logic            fall_detected;
  logic            collision_detected;

  modport source (
    output valid, accel_magnitude, rate_magnitude, fall_detected,
           collision_detected,
    input  ready
  );

  modport sink (
    input  valid, accel_magnitude, rate_magnitude, fall_detected,
           collision_detected,
    output ready
  );
endinterface

// File: src/mfcd_square_sum.sv
// ----------------------------------------------------------------------------
// mfcd_square_sum
// Two register stages: square each axis and test tilt, then add the three
// squares of each vector.
// ----------------------------------------------------------------------------
module mfcd_square_sum (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           adv,
  input  logic [mfcd_pkg::AngleLimW-1:0] angle_limit,
  mfcd_sample_if.sink                    sample,
  output mfcd_pkg::mfcd_sum_t            sum_out
);
  import mfcd_pkg::*;

  logic signed [2*AxisW-1:0] prod_ax, prod_ay, prod_az;
  logic signed [2*AxisW-1:0] prod_gx, prod_gy, prod_gz;
  logic [AngleW-1:0]         abs_pitch, abs_roll;
  logic                      tilt_next;

  logic                      sq_valid;
  logic                      sq_tilt;
  logic [SquareW-1:0]        sq_ax, sq_ay, sq_az, sq_gx, sq_gy, sq_gz;

  assign prod_ax = sample.accel_x * sample.accel_x;
  assign prod_ay = sample.accel_y * sample.accel_y;
  assign prod_az = sample.accel_z * sample.accel_z;
  assign prod_gx = sample.rate_x * sample.rate_x;
  assign prod_gy = sample.rate_y * sample.rate_y;
  assign prod_gz = sample.rate_z * sample.rate_z;

  assign abs_pitch = sample.pitch_tenths[AngleW-1]
                   ? AngleW'(~sample.pitch_tenths + AngleW'(1))
                   : AngleW'(sample.pitch_tenths);
  assign abs_roll  = sample.roll_tenths[AngleW-1]
                   ? AngleW'(~sample.roll_tenths + AngleW'(1))
                   : AngleW'(sample.roll_tenths);
  assign tilt_next = (abs_pitch > AngleW'(angle_limit))
                  || (abs_roll > AngleW'(angle_limit));

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
    end else if (adv) begin
      sq_valid <= sample.valid;
      sq_tilt  <= tilt_next;
      sq_ax    <= SquareW'(prod_ax);
      sq_ay    <= SquareW'(prod_ay);
      sq_az    <= SquareW'(prod_az);
      sq_gx    <= SquareW'(prod_gx);
      sq_gy    <= SquareW'(prod_gy);
      sq_gz    <= SquareW'(prod_gz);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_out.valid <= 1'b0;
    end else if (adv) begin
      sum_out.valid     <= sq_valid;
      sum_out.tilt      <= sq_tilt;
      sum_out.accel_sum <= SumW'(sq_ax) + SumW'(sq_ay) + SumW'(sq_az);
      sum_out.rate_sum  <= SumW'(sq_gx) + SumW'(sq_gy) + SumW'(sq_gz);
    end
  end

endmodule

// File: src/mfcd_isqrt_pipe.sv
// ----------------------------------------------------------------------------
// mfcd_isqrt_pipe
// Floor square root of both sums, one result bit per register stage,
// restoring digit-by-digit method.
// ----------------------------------------------------------------------------
module mfcd_isqrt_pipe (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  mfcd_pkg::mfcd_sum_t  sum_in,
  output mfcd_pkg::mfcd_root_t root_out
);
  import mfcd_pkg::*;

  localparam int RemW   = MagW + 1;
  localparam int Stages = MagW;

  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [MagW-1:0] root;
  } lane_t;

  typedef struct packed {
    logic            valid;
    logic            tilt;
    logic [SumW-1:0] accel_n;
    logic [SumW-1:0] rate_n;
    lane_t           accel;
    lane_t           rate;
  } stage_t;

  function automatic lane_t root_step(lane_t cur, logic [1:0] pair);
    logic [RemW+1:0] shifted;
    logic [RemW+1:0] trial;
    lane_t           nxt;
    shifted = {cur.rem, pair};
    trial   = {{(RemW - MagW){1'b0}}, cur.root, 2'b01};
    if (shifted >= trial) begin
      nxt.rem  = RemW'(shifted - trial);
      nxt.root = {cur.root[MagW-2:0], 1'b1};
    end else begin
      nxt.rem  = RemW'(shifted);
      nxt.root = {cur.root[MagW-2:0], 1'b0};
    end
    return nxt;
  endfunction

  stage_t stg [Stages+1];

  assign stg[0].valid   = sum_in.valid;
  assign stg[0].tilt    = sum_in.tilt;
  assign stg[0].accel_n = sum_in.accel_sum;
  assign stg[0].rate_n  = sum_in.rate_sum;
  assign stg[0].accel   = '0;
  assign stg[0].rate    = '0;

  for (genvar k = 0; k < Stages; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        stg[k+1].valid <= 1'b0;
      end else if (adv) begin
        stg[k+1].valid   <= stg[k].valid;
        stg[k+1].tilt    <= stg[k].tilt;
        stg[k+1].accel_n <= stg[k].accel_n;
        stg[k+1].rate_n  <= stg[k].rate_n;
        stg[k+1].accel   <= root_step(stg[k].accel, stg[k].accel_n[SumW-1-2*k -: 2]);
        stg[k+1].rate    <= root_step(stg[k].rate, stg[k].rate_n[SumW-1-2*k -: 2]);
      end
    end
  end

  assign root_out.valid     = stg[Stages].valid;
  assign root_out.tilt      = stg[Stages].tilt;
  assign root_out.accel_mag = stg[Stages].accel.root;
  assign root_out.rate_mag  = stg[Stages].rate.root;

endmodule

// File: src/motion_fall_collision_detect.sv
// ----------------------------------------------------------------------------
// motion_fall_collision_detect
// Per-sample acceleration and rate magnitudes with fall and collision flags.
//
// Channel  Dir  Transfer when          Payload
// sample   in   valid && ready         accel/rate x,y,z, pitch, roll
// result   out  valid && ready         magnitudes, fall and collision flags
// cfg      in   cfg_we high            cfg_index, cfg_data
//
// Takes one sample per cycle while sample.ready is high; a result passes through
// square, sum, sixteen square-root bit stages and the limit compare register.
// Reset clears all stage valid bits and loads the default limits.
// A held result parks the next one in a skid register; sample.ready then
// drops and every stage holds until the result is taken.
// ----------------------------------------------------------------------------
module motion_fall_collision_detect (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [mfcd_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [mfcd_pkg::CfgDataW-1:0]  cfg_data,
  mfcd_sample_if.sink                    sample,
  mfcd_result_if.source                  result
);
  import mfcd_pkg::*;

  typedef struct packed {
    logic [MagW-1:0] accel_mag;
    logic [MagW-1:0] rate_mag;
    logic            fall;
    logic            coll;
  } res_t;

  logic [AngleLimW-1:0] angle_limit;
  logic [LimitW-1:0]    accel_low_limit;
  logic [LimitW-1:0]    accel_high_limit;
  logic [LimitW-1:0]    rate_limit;

  logic       adv;
  mfcd_sum_t  sum_q;
  mfcd_root_t root_q;
  res_t       res_next;
  res_t       out_q;
  res_t       skid_q;
  logic       out_valid;
  logic       skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_limit      <= AngleLimitReset;
      accel_low_limit  <= AccelLowReset;
      accel_high_limit <= AccelHighReset;
      rate_limit       <= RateLimitReset;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ANGLE_LIMIT: angle_limit      <= cfg_data[AngleLimW-1:0];
        REG_ACCEL_LOW:   accel_low_limit  <= cfg_data[LimitW-1:0];
        REG_ACCEL_HIGH:  accel_high_limit <= cfg_data[LimitW-1:0];
        REG_RATE_LIMIT:  rate_limit       <= cfg_data[LimitW-1:0];
        default: ;
      endcase
    end
  end

  assign adv          = !skid_valid;
  assign sample.ready = adv;

  mfcd_square_sum u_square_sum (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .angle_limit (angle_limit),
    .sample      (sample),
    .sum_out     (sum_q)
  );

  mfcd_isqrt_pipe u_isqrt_pipe (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .sum_in   (sum_q),
    .root_out (root_q)
  );

  always_comb begin
    res_next.accel_mag = root_q.accel_mag;
    res_next.rate_mag  = root_q.rate_mag;
    res_next.coll      = (root_q.accel_mag < accel_low_limit)
                      || (root_q.accel_mag > accel_high_limit);
    res_next.fall      = res_next.coll && root_q.tilt
                      && (root_q.rate_mag > rate_limit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (result.ready) begin
        out_q      <= skid_q;
        skid_valid <= 1'b0;
      end
    end else if (root_q.valid) begin
      if (!out_valid || result.ready) begin
        out_q     <= res_next;
        out_valid <= 1'b1;
      end else begin
        skid_q     <= res_next;
        skid_valid <= 1'b1;
      end
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign result.valid              = out_valid;
  assign result.accel_magnitude    = out_q.accel_mag;
  assign result.rate_magnitude     = out_q.rate_mag;
  assign result.fall_detected      = out_q.fall;
  assign result.collision_detected = out_q.coll;

  a_skid_behind_out : assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full while output register empty");

  a_fall_needs_coll : assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.fall_detected) |-> result.collision_detected)
    else $error("fall flagged without collision window violation");

  a_skid_holds : assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !result.ready) |=> (skid_valid && $stable(skid_q)))
    else $error("parked result lost or changed while output stalled");

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the motion fall and collision detector. A model of
// the magnitude, window and tilt logic predicts each result from the samples
// accepted on the sample channel, and a scoreboard compares every result
// transfer, field by field and in order. The run walks through the default
// limits, the extreme and inverted windows and random limit settings. It
// drives directed edge samples and then random ones, with random gaps on
// both channels and a long result back-pressure stretch.
// ----------------------------------------------------------------------------
module tb_top;
  import mfcd_pkg::*;

  localparam int CycleLimit   = 400000;
  localparam int HoldCycles   = 300;
  localparam int SettleCycles = 24;
  localparam int MaxReports   = 10;

  typedef struct packed {
    logic signed [AxisW-1:0]  ax;
    logic signed [AxisW-1:0]  ay;
    logic signed [AxisW-1:0]  az;
    logic signed [AxisW-1:0]  rx;
    logic signed [AxisW-1:0]  ry;
    logic signed [AxisW-1:0]  rz;
    logic signed [AngleW-1:0] pitch;
    logic signed [AngleW-1:0] roll;
  } sample_t;

  typedef struct packed {
    logic [MagW-1:0] accel_mag;
    logic [MagW-1:0] rate_mag;
    logic            fall;
    logic            coll;
  } result_t;

  class fall_scoreboard;
    logic [AngleLimW-1:0] angle_lim;
    logic [LimitW-1:0]    low_lim;
    logic [LimitW-1:0]    high_lim;
    logic [LimitW-1:0]    rate_lim;
    result_t              expected_q[$];
    int                   mismatches;
    int                   checked;
    int                   falls;
    int                   collisions;

    function new();
      angle_lim  = AngleLimitReset;
      low_lim    = AccelLowReset;
      high_lim   = AccelHighReset;
      rate_lim   = RateLimitReset;
      mismatches = 0;
      checked    = 0;
      falls      = 0;
      collisions = 0;
    endfunction

    function void load_limit(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_ANGLE_LIMIT: angle_lim = data[AngleLimW-1:0];
        REG_ACCEL_LOW:   low_lim   = data[LimitW-1:0];
        REG_ACCEL_HIGH:  high_lim  = data[LimitW-1:0];
        REG_RATE_LIMIT:  rate_lim  = data[LimitW-1:0];
        default: ;
      endcase
    endfunction

    function int isqrt(longint n);
      longint cand;
      int     root;
      root = 0;
      for (int b = 15; b >= 0; b--) begin
        cand = longint'(root | (1 << b));
        if (cand * cand <= n) root = root | (1 << b);
      end
      return root;
    endfunction

    function result_t classify(sample_t s);
      longint  accel_sq;
      longint  rate_sq;
      int      am;
      int      rm;
      int      abs_pitch;
      int      abs_roll;
      bit      tilt;
      result_t r;
      accel_sq = longint'(s.ax) * longint'(s.ax) + longint'(s.ay) * longint'(s.ay)
               + longint'(s.az) * longint'(s.az);
      rate_sq  = longint'(s.rx) * longint'(s.rx) + longint'(s.ry) * longint'(s.ry)
               + longint'(s.rz) * longint'(s.rz);
      am = isqrt(accel_sq);
      rm = isqrt(rate_sq);
      abs_pitch = int'(s.pitch);
      abs_roll  = int'(s.roll);
      if (abs_pitch < 0) abs_pitch = -abs_pitch;
      if (abs_roll < 0) abs_roll = -abs_roll;
      tilt = (abs_pitch > int'(angle_lim)) || (abs_roll > int'(angle_lim));
      r.accel_mag = 16'(am);
      r.rate_mag  = 16'(rm);
      r.coll      = (am < int'(low_lim)) || (am > int'(high_lim));
      r.fall      = r.coll && tilt && (rm > int'(rate_lim));
      return r;
    endfunction

    function void note_sample(sample_t s);
      result_t r;
      r = classify(s);
      if (r.fall) falls++;
      if (r.coll) collisions++;
      expected_q.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("[%0t] result with nothing pending: accel %0d rate %0d fall %0b coll %0b",
                   $time, got.accel_mag, got.rate_mag, got.fall, got.coll);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.accel_mag != want.accel_mag || got.rate_mag != want.rate_mag ||
          got.fall != want.fall || got.coll != want.coll) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display({"[%0t] result %0d: accel %0d/%0d rate %0d/%0d ",
                    "fall %0b/%0b coll %0b/%0b (exp/got)"},
                   $time, checked, want.accel_mag, got.accel_mag, want.rate_mag,
                   got.rate_mag, want.fall, got.fall, want.coll, got.coll);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void flag_leftovers();
      if (expected_q.size() != 0) begin
        mismatches += expected_q.size();
        $display("[%0t] %0d results never arrived", $time, expected_q.size());
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CfgIndexW-1:0] cfg_index;
  logic [CfgDataW-1:0]  cfg_data;

  mfcd_sample_if smp ();
  mfcd_result_if res ();

  fall_scoreboard sb = new();
  bit             calm;
  bit             hold_req;
  int             cycle_count;
  int             samples_sent;
  int             settings_run;

  motion_fall_collision_detect dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (smp),
    .result    (res)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[%0t] run did not finish within %0d cycles", $time, CycleLimit);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int pick_gap(input int idle_pct);
    int draw;
    if (calm) return 0;
    draw = $urandom_range(0, 99);
    if (draw >= idle_pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic sample_t mk(int ax, int ay, int az, int rx, int ry, int rz,
                                 int pitch, int roll);
    sample_t s;
    s.ax    = 16'(ax);
    s.ay    = 16'(ay);
    s.az    = 16'(az);
    s.rx    = 16'(rx);
    s.ry    = 16'(ry);
    s.rz    = 16'(rz);
    s.pitch = 12'(pitch);
    s.roll  = 12'(roll);
    return s;
  endfunction

  function automatic int near_limit(int base, int top);
    int v;
    v = base + $urandom_range(0, 2) - 1;
    if (v < 0) v = 0;
    if (v > top) v = top;
    if ($urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    int      kind;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      s = sample_t'({$urandom, $urandom, $urandom, $urandom});
    end else if (kind < 65) begin
      s = mk($urandom_range(0, 40000) - 20000, $urandom_range(0, 40000) - 20000,
             $urandom_range(0, 40000) - 20000, $urandom_range(0, 4000) - 2000,
             $urandom_range(0, 4000) - 2000, $urandom_range(0, 4000) - 2000,
             $urandom_range(0, 3600) - 1800, $urandom_range(0, 3600) - 1800);
    end else if (kind < 85) begin
      s = mk(near_limit($urandom_range(0, 1) ? int'(sb.low_lim) : int'(sb.high_lim), 32767),
             0, 0, 0, 0, near_limit(int'(sb.rate_lim), 32767),
             near_limit(int'(sb.angle_lim), 2047), near_limit(int'(sb.angle_lim), 2047));
    end else begin
      s = mk($urandom_range(0, 600) - 300, $urandom_range(0, 600) - 300,
             $urandom_range(0, 600) - 300, $urandom_range(0, 600) - 300,
             $urandom_range(0, 600) - 300, $urandom_range(0, 600) - 300,
             $urandom_range(0, 100) - 50, $urandom_range(0, 100) - 50);
    end
    return s;
  endfunction

  task automatic push_sample(input sample_t s);
    smp.valid        <= 1'b1;
    smp.accel_x      <= s.ax;
    smp.accel_y      <= s.ay;
    smp.accel_z      <= s.az;
    smp.rate_x       <= s.rx;
    smp.rate_y       <= s.ry;
    smp.rate_z       <= s.rz;
    smp.pitch_tenths <= s.pitch;
    smp.roll_tenths  <= s.roll;
    @(posedge clk);
    while (!smp.ready) @(posedge clk);
    sb.note_sample(s);
    samples_sent++;
  endtask

  task automatic sender_gap(input int n);
    if (n > 0) begin
      smp.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    smp.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.load_limit(idx, data);
  endtask

  task automatic write_limits(input logic [CfgDataW-1:0] ang, input logic [CfgDataW-1:0] lo,
                              input logic [CfgDataW-1:0] hi, input logic [CfgDataW-1:0] rt);
    drain();
    cfg_write(REG_ANGLE_LIMIT, ang);
    cfg_write(REG_ACCEL_LOW, lo);
    cfg_write(REG_ACCEL_HIGH, hi);
    cfg_write(REG_RATE_LIMIT, rt);
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  task automatic run_random(input int count, input int hold_at, input int drain_at);
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_req = 1'b1;
      if (i == drain_at) drain();
      push_sample(random_sample());
      sender_gap(pick_gap(35));
    end
  endtask

  initial begin : result_sink
    int      stall_left;
    int      hold_left;
    result_t got;
    stall_left = 0;
    hold_left  = 0;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res.valid && res.ready) begin
        got.accel_mag = res.accel_magnitude;
        got.rate_mag  = res.rate_magnitude;
        got.fall      = res.fall_detected;
        got.coll      = res.collision_detected;
        sb.check_result(got);
      end
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res.ready <= 1'b0;
      end else begin
        stall_left = pick_gap(20);
        res.ready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  initial begin : stimulus
    sample_t directed_q[$];
    calm         = 1'b0;
    hold_req     = 1'b0;
    samples_sent = 0;
    settings_run = 1;
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_index        <= REG_ANGLE_LIMIT;
    cfg_data         <= '0;
    smp.valid        <= 1'b0;
    smp.accel_x      <= '0;
    smp.accel_y      <= '0;
    smp.accel_z      <= '0;
    smp.rate_x       <= '0;
    smp.rate_y       <= '0;
    smp.rate_z       <= '0;
    smp.pitch_tenths <= '0;
    smp.roll_tenths  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default limits: window edges, tilt edges, rate edge, extreme vectors
    directed_q.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0));
    directed_q.push_back(mk(9999, 0, 0, 101, 0, 0, 601, 0));
    directed_q.push_back(mk(10000, 0, 0, 101, 0, 0, 601, 0));
    directed_q.push_back(mk(20000, 0, 0, 101, 0, 0, 0, 601));
    directed_q.push_back(mk(20001, 0, 0, 101, 0, 0, 0, 601));
    directed_q.push_back(mk(20001, 0, 0, 100, 0, 0, 601, 0));
    directed_q.push_back(mk(20001, 0, 0, 101, 0, 0, 600, -600));
    directed_q.push_back(mk(-20001, 0, 0, 0, -101, 0, -601, 0));
    directed_q.push_back(mk(-32768, -32768, -32768, -32768, -32768, -32768, -2048, -2048));
    directed_q.push_back(mk(32767, 32767, 32767, 32767, 32767, 32767, 2047, 2047));
    directed_q.push_back(mk(3, 4, 0, -3, -4, -12, 0, 0));
    directed_q.push_back(mk(3, 4, 1, 0, 0, -1, 0, 0));
    directed_q.push_back(mk(-32768, 0, 0, 0, 0, 32767, 1800, -1800));
    directed_q.push_back(mk(16384, -100, 0, 20, 30, 40, -1801, 0));
    directed_q.push_back(mk(5773, 5773, 5774, 58, 58, 58, 0, 1200));
    directed_q.push_back(mk(5773, 5773, 5774, 58, 58, 59, 0, 1200));
    directed_q.push_back(mk(16'h5555, 16'hAAAA, 1, 16'hAAAA, 16'h5555, -1, 12'h555, 12'hAAA));
    directed_q.push_back(mk(0, 0, 0, 0, 32767, 0, 0, -2048));
    foreach (directed_q[i]) begin
      push_sample(directed_q[i]);
      sender_gap(pick_gap(35));
    end
    run_random(140, -1, -1);

    // degenerate zero limits, no idling on either side
    calm = 1'b1;
    write_limits('0, '0, '0, '0);
    run_random(100, -1, -1);
    calm = 1'b0;

    // oversized angle write is masked; every magnitude falls below the window
    write_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(90, -1, -1);

    // inverted window with a long result hold-off
    write_limits(16'd1200, 16'd30000, 16'd5000, 16'd2000);
    run_random(110, 20, -1);

    // narrow window around one g at the largest legal angle
    write_limits(16'd1800, 16'd16384, 16'd16500, 16'd1000);
    run_random(130, -1, -1);

    repeat (2) begin
      write_limits(16'($urandom_range(0, 2047)), 16'($urandom), 16'($urandom),
                   16'($urandom_range(0, 3000)));
      run_random(120, -1, -1);
    end

    // back to the reset limits, with a full drain part way through
    write_limits(16'(AngleLimitReset), AccelLowReset, AccelHighReset, RateLimitReset);
    run_random(120, -1, 60);

    smp.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    sb.flag_leftovers();

    $display("covered %0d samples over %0d limit settings in %0d cycles",
             samples_sent, settings_run, cycle_count);
    $display("checked %0d results (%0d collisions, %0d falls predicted), %0d mismatches",
             sb.checked, sb.collisions, sb.falls, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: sim.f
src/mfcd_pkg.sv
src/mfcd_ifs.sv
src/mfcd_square_sum.sv
src/mfcd_isqrt_pipe.sv
src/motion_fall_collision_detect.sv
sim/tb_top.sv
